FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the glyph row generator modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge of clk while rst is low.
`define SGR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that a condition in one cycle implies another in the next cycle.
`define SGR_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

FILE: hw/rtl/sgr_pkg.sv
// Shared types, constants and the 5x8 font table of the glyph row generator.
package sgr_pkg;

  localparam int PanelWidthDefault = 240;
  localparam int MaxScaleDefault   = 8;

  localparam int GlyphCols  = 5;
  localparam int CellCols   = 6;
  localparam int GlyphRows  = 8;
  localparam int QueueDepth = 2;

  localparam logic [7:0] FirstCode = 8'd32;
  localparam logic [7:0] EndCode   = 8'd127;

  // Configuration register indexes.
  localparam logic [1:0] RegGlyphScale = 2'd0;
  localparam logic [1:0] RegFgColour   = 2'd1;
  localparam logic [1:0] RegBgColour   = 2'd2;

  // Glyph columns are stored with column 0 in the top byte; bit 0 of a column is the top row.
  typedef logic [GlyphCols*8-1:0] glyph_t;

  // One character ready for drawing.
  typedef struct packed {
    glyph_t      glyph;
    logic [8:0]  x_first;
    logic [8:0]  x_last;
    logic [15:0] y;
    logic [3:0]  scale;
  } job_t;

  typedef struct packed {
    logic [3:0]  glyph_scale;
    logic [15:0] fg;
    logic [15:0] bg;
  } cfg_t;

  function automatic glyph_t sgr_font(input logic [7:0] code);
    glyph_t g;
    begin
      case (code)
        8'd33:  g = 40'h00005F0000;
        8'd34:  g = 40'h0007000700;
        8'd35:  g = 40'h147F147F14;
        8'd36:  g = 40'h242A7F2A12;
        8'd37:  g = 40'h2313086462;
        8'd38:  g = 40'h3649552250;
        8'd39:  g = 40'h0005030000;
        8'd40:  g = 40'h001C224100;
        8'd41:  g = 40'h0041221C00;
        8'd42:  g = 40'h14083E0814;
        8'd43:  g = 40'h08083E0808;
        8'd44:  g = 40'h0050300000;
        8'd45:  g = 40'h0808080808;
        8'd46:  g = 40'h0060600000;
        8'd47:  g = 40'h2010080402;
        8'd48:  g = 40'h3E5149453E;
        8'd49:  g = 40'h00427F4000;
        8'd50:  g = 40'h4261514946;
        8'd51:  g = 40'h2141454B31;
        8'd52:  g = 40'h1814127F10;
        8'd53:  g = 40'h2745454539;
        8'd54:  g = 40'h3C4A494930;
        8'd55:  g = 40'h0171090503;
        8'd56:  g = 40'h3649494936;
        8'd57:  g = 40'h064949291E;
        8'd58:  g = 40'h0036360000;
        8'd59:  g = 40'h0056360000;
        8'd60:  g = 40'h0008142241;
        8'd61:  g = 40'h1414141414;
        8'd62:  g = 40'h4122140800;
        8'd63:  g = 40'h0201510906;
        8'd64:  g = 40'h324979413E;
        8'd65:  g = 40'h7E1111117E;
        8'd66:  g = 40'h7F49494936;
        8'd67:  g = 40'h3E41414122;
        8'd68:  g = 40'h7F4141221C;
        8'd69:  g = 40'h7F49494941;
        8'd70:  g = 40'h7F09090101;
        8'd71:  g = 40'h3E41415132;
        8'd72:  g = 40'h7F0808087F;
        8'd73:  g = 40'h00417F4100;
        8'd74:  g = 40'h2040413F01;
        8'd75:  g = 40'h7F08142241;
        8'd76:  g = 40'h7F40404040;
        8'd77:  g = 40'h7F0204027F;
        8'd78:  g = 40'h7F0408107F;
        8'd79:  g = 40'h3E4141413E;
        8'd80:  g = 40'h7F09090906;
        8'd81:  g = 40'h3E4151215E;
        8'd82:  g = 40'h7F09192946;
        8'd83:  g = 40'h4649494931;
        8'd84:  g = 40'h01017F0101;
        8'd85:  g = 40'h3F4040403F;
        8'd86:  g = 40'h1F2040201F;
        8'd87:  g = 40'h7F2018207F;
        8'd88:  g = 40'h6314081463;
        8'd89:  g = 40'h0304780403;
        8'd90:  g = 40'h6151494543;
        8'd91:  g = 40'h00007F4141;
        8'd92:  g = 40'h0204081020;
        8'd93:  g = 40'h41417F0000;
        8'd94:  g = 40'h0402010204;
        8'd95:  g = 40'h4040404040;
        8'd96:  g = 40'h0001020400;
        8'd97:  g = 40'h2054545478;
        8'd98:  g = 40'h7F48444438;
        8'd99:  g = 40'h3844444420;
        8'd100: g = 40'h384444487F;
        8'd101: g = 40'h3854545418;
        8'd102: g = 40'h087E090102;
        8'd103: g = 40'h081454543C;
        8'd104: g = 40'h7F08040478;
        8'd105: g = 40'h00447D4000;
        8'd106: g = 40'h2040443D00;
        8'd107: g = 40'h007F102844;
        8'd108: g = 40'h00417F4000;
        8'd109: g = 40'h7C04180478;
        8'd110: g = 40'h7C08040478;
        8'd111: g = 40'h3844444438;
        8'd112: g = 40'h7C14141408;
        8'd113: g = 40'h081414187C;
        8'd114: g = 40'h7C08040408;
        8'd115: g = 40'h4854545420;
        8'd116: g = 40'h043F444020;
        8'd117: g = 40'h3C4040207C;
        8'd118: g = 40'h1C2040201C;
        8'd119: g = 40'h3C4030403C;
        8'd120: g = 40'h4428102844;
        8'd121: g = 40'h0C5050503C;
        8'd122: g = 40'h4464544C44;
        8'd123: g = 40'h0008364100;
        8'd124: g = 40'h00007F0000;
        8'd125: g = 40'h0041360800;
        8'd126: g = 40'h08082A1C08;
        default: g = '0;  // space and every code outside the printable range
      endcase
      return g;
    end
  endfunction

endpackage

FILE: hw/rtl/sgr_front.sv
// Front end: takes characters, tracks the cursor and string stop, and queues glyph jobs.
module sgr_front #(
  parameter int PANEL_WIDTH = sgr_pkg::PanelWidthDefault,
  parameter int MAX_SCALE   = sgr_pkg::MaxScaleDefault
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    char_code,
  input  logic          new_string,
  input  logic [15:0]   start_x,
  input  logic [15:0]   start_y,
  input  logic [3:0]    glyph_scale,
  input  logic          queue_full,
  output logic          push,
  output sgr_pkg::job_t push_job
);
  import sgr_pkg::*;

  localparam logic [15:0] PanelW   = 16'(PANEL_WIDTH);
  localparam logic [3:0]  ScaleMax = 4'(MAX_SCALE);

  logic [15:0] cursor_x;
  logic [15:0] cursor_x_next;
  logic [15:0] cursor_y;
  logic        stopped;
  logic        stopped_next;

  logic [15:0] cx;
  logic [15:0] cy;
  logic        stop_cur;
  logic [3:0]  scale;
  logic [5:0]  cw;
  logic        fits;
  logic        accept;

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    scale = glyph_scale;
    if (scale == 4'd0) begin
      scale = 4'd1;
    end
    if (scale > ScaleMax) begin
      scale = ScaleMax;
    end
  end

  // Cell width is six times the scale.
  assign cw = {scale, 2'b00} + {1'b0, scale, 1'b0};

  assign cx       = new_string ? start_x : cursor_x;
  assign cy       = new_string ? start_y : cursor_y;
  assign stop_cur = new_string ? 1'b0 : stopped;
  assign fits     = (cx < PanelW) && ({10'd0, cw} <= PanelW);

  assign push = accept && !stop_cur && fits;

  always_comb begin
    push_job.glyph   = sgr_font(char_code);
    push_job.x_first = cx[8:0];
    push_job.x_last  = cx[8:0] + {3'd0, cw} - 9'd1;
    push_job.y       = cy;
    push_job.scale   = scale;
  end

  always_comb begin
    cursor_x_next = cx;
    stopped_next  = stop_cur;
    if (!stop_cur) begin
      if (fits) begin
        cursor_x_next = cx + {10'd0, cw};
      end else begin
        stopped_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_x <= '0;
      cursor_y <= '0;
      stopped  <= 1'b0;
    end else if (accept) begin
      cursor_x <= cursor_x_next;
      cursor_y <= cy;
      stopped  <= stopped_next;
    end
  end

endmodule

FILE: hw/rtl/sgr_queue.sv
// Short job queue between the front end and the row generator.
`include "assert_macros.svh"
module sgr_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  sgr_pkg::job_t push_job,
  input  logic          pop,
  output logic          full,
  output logic          empty,
  output sgr_pkg::job_t head
);
  import sgr_pkg::*;

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QueueDepth - 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(QueueDepth);

  job_t            entries [QueueDepth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign full  = (count == DepthCnt);
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `SGR_ASSERT(a_no_push_full, !(push && full), "job pushed into a full queue")
  `SGR_ASSERT(a_no_pop_empty, !(pop && empty), "job popped from an empty queue")
  `SGR_ASSERT_NEXT(a_count_up, push && !pop, count == $past(count) + 1'b1, "count did not grow")

endmodule

FILE: hw/rtl/sgr_back.sv
// Row generator: walks the head job row by row into the registered output word.
`include "assert_macros.svh"
module sgr_back #(
  parameter int MAX_SCALE = sgr_pkg::MaxScaleDefault
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          head_valid,
  input  sgr_pkg::job_t head,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [8:0]    out_x_first,
  output logic [8:0]    out_x_last,
  output logic [15:0]   out_row_y,
  output logic [47:0]   out_mask,
  output logic          out_last
);
  import sgr_pkg::*;

  localparam logic [3:0] ScaleMax = 4'(MAX_SCALE);
  localparam logic [2:0] LastRow  = 3'(GlyphRows - 1);

  logic [2:0]  row;
  logic [2:0]  sy;
  logic [5:0]  yoff;
  logic        adv;
  logic        sy_last;
  logic        job_last;
  logic [47:0] seg;
  logic [47:0] mask;
  logic [7:0]  col_bits;

  assign adv      = head_valid && (!out_valid || out_ready);
  assign sy_last  = (sy == 3'(head.scale - 4'd1));
  assign job_last = sy_last && (row == LastRow);
  assign pop      = adv && job_last;

  // Each set font pixel becomes a run of scale ones at column times scale.
  assign seg = (48'd1 << head.scale) - 48'd1;

  always_comb begin
    mask     = '0;
    col_bits = '0;
    for (int col = 0; col < GlyphCols; col++) begin
      col_bits = head.glyph[8*(GlyphCols-1-col) +: 8];
      if (col_bits[row]) begin
        mask = mask | (seg << (6'(col) * {2'd0, head.scale}));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row       <= '0;
      sy        <= '0;
      yoff      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (adv) begin
        out_valid <= 1'b1;
        if (job_last) begin
          row  <= '0;
          sy   <= '0;
          yoff <= '0;
        end else begin
          yoff <= yoff + 6'd1;
          if (sy_last) begin
            sy  <= '0;
            row <= row + 3'd1;
          end else begin
            sy <= sy + 3'd1;
          end
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_x_first <= head.x_first;
      out_x_last  <= head.x_last;
      out_row_y   <= head.y + {10'd0, yoff};
      out_mask    <= mask;
      out_last    <= job_last;
    end
  end

  `SGR_ASSERT(a_sub_row_range, !head_valid || ({1'b0, sy} < head.scale),
              "sub-row counter beyond scale")
  `SGR_ASSERT(a_scale_range, !head_valid || (head.scale != 4'd0 && head.scale <= ScaleMax),
              "job scale out of range")

endmodule

FILE: hw/rtl/scaled_glyph_row_generator_core.sv
// Top level of the scaled glyph row generator: configuration registers and stream ports.
//
//  channel   direction  handshake          payload
//  s_*       in         s_tvalid/s_tready  character, string start flag, start position
//  m_*       out        m_tvalid/m_tready  one pixel row of a character cell
//  cfg_*     in         cfg_valid/cfg_ready register index and value
//
// A drawn character yields 8 times scale output words, one per clock cycle while the
// output is not stalled. Characters that draw nothing (stopped string, past the panel
// edge) never reach the job queue and yield no output words.
// The front end keeps accepting characters while the two-entry job queue has room,
// so a new character is taken while earlier rows are still being produced.
// Reset clears the cursor, stop flag, queue and output valid; configuration returns
// to scale 1, white foreground, black background. There is no clearing pass.
// Output backpressure stalls only the row generator until the queue fills.
module scaled_glyph_row_generator_core #(
  parameter int PANEL_WIDTH = sgr_pkg::PanelWidthDefault,
  parameter int MAX_SCALE   = sgr_pkg::MaxScaleDefault
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [39:0]  s_tdata,   // char_code[7:0], start_x[23:8], start_y[39:24]
  input  logic         s_tuser,   // new_string
  output logic         m_tvalid,
  input  logic         m_tready,
  // window_x_first[8:0], window_x_last[17:9], row_y[33:18], pixel_mask[81:34],
  // fg_out[97:82], bg_out[113:98], zero fill [119:114]
  output logic [119:0] m_tdata,
  output logic         m_tlast,   // last_row
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_data
);
  import sgr_pkg::*;

  cfg_t  cfg;
  logic  push;
  job_t  push_job;
  logic  pop;
  logic  full;
  logic  empty;
  job_t  head;

  logic [8:0]  x_first;
  logic [8:0]  x_last;
  logic [15:0] row_y;
  logic [47:0] mask;

  // Registers are always writable; the user, not the block, must write only when idle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.glyph_scale <= 4'd1;
      cfg.fg          <= 16'hFFFF;
      cfg.bg          <= 16'h0000;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        RegGlyphScale: cfg.glyph_scale <= cfg_data[3:0];
        RegFgColour:   cfg.fg          <= cfg_data;
        RegBgColour:   cfg.bg          <= cfg_data;
        default:       ;  // writes to unused indexes are dropped
      endcase
    end
  end

  sgr_front #(
    .PANEL_WIDTH (PANEL_WIDTH),
    .MAX_SCALE   (MAX_SCALE)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .char_code   (s_tdata[7:0]),
    .new_string  (s_tuser),
    .start_x     (s_tdata[23:8]),
    .start_y     (s_tdata[39:24]),
    .glyph_scale (cfg.glyph_scale),
    .queue_full  (full),
    .push        (push),
    .push_job    (push_job)
  );

  sgr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .full     (full),
    .empty    (empty),
    .head     (head)
  );

  sgr_back #(
    .MAX_SCALE (MAX_SCALE)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (!empty),
    .head        (head),
    .pop         (pop),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_x_first (x_first),
    .out_x_last  (x_last),
    .out_row_y   (row_y),
    .out_mask    (mask),
    .out_last    (m_tlast)
  );

  // Colours come straight from the registers; the user must change them only when idle.
  assign m_tdata = {6'd0, cfg.bg, cfg.fg, mask, row_y, x_last, x_first};

endmodule

FILE: sim/tb_top.sv
// Self-checking stream testbench for the scaled glyph row generator core.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sgr_pkg::*;

  // Cycles allowed for characters that draw nothing to pass through after the
  // last expected row word has come out, before the block counts as idle.
  localparam int SettleCycles  = 16;
  // Length of the long output hold-off that fills the job queue.
  localparam int LongHold      = 200;
  // Cycles with no handshake on any channel before the run is abandoned.
  localparam int WatchdogLimit = 2000;
  localparam int PhaseCount    = 7;
  localparam int PhaseChars    = 36;

  // One character word as it travels on the input stream.
  typedef struct packed {
    logic [7:0]  char_code;
    logic        new_string;
    logic [15:0] start_x;
    logic [15:0] start_y;
  } char_word_t;

  // One pixel row word as it comes out of the block.
  typedef struct {
    logic [8:0]  x_first;
    logic [8:0]  x_last;
    logic [15:0] row_y;
    logic [47:0] pixel_mask;
    logic [15:0] fg;
    logic [15:0] bg;
    logic        last_row;
  } row_word_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [39:0]  s_tdata = '0;   // char_code[7:0], start_x[23:8], start_y[39:24]
  logic         s_tuser = 1'b0; // new_string
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  // window_x_first[8:0], window_x_last[17:9], row_y[33:18], pixel_mask[81:34],
  // fg_out[97:82], bg_out[113:98], zero fill [119:114]
  logic [119:0] m_tdata;
  logic         m_tlast;        // last_row
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [1:0]   cfg_index = '0;
  logic [15:0]  cfg_data = '0;

  scaled_glyph_row_generator_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Font for codes 32..126. Each entry holds the five column bytes with the
  // leftmost column in the top byte; bit 0 of a column byte is the top row.
  logic [39:0] glyph_rom [0:94] = '{
    40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14, 40'h242A7F2A12,
    40'h2313086462, 40'h3649552250, 40'h0005030000, 40'h001C224100, 40'h0041221C00,
    40'h14083E0814, 40'h08083E0808, 40'h0050300000, 40'h0808080808, 40'h0060600000,
    40'h2010080402, 40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
    40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503, 40'h3649494936,
    40'h064949291E, 40'h0036360000, 40'h0056360000, 40'h0008142241, 40'h1414141414,
    40'h4122140800, 40'h0201510906, 40'h324979413E, 40'h7E1111117E, 40'h7F49494936,
    40'h3E41414122, 40'h7F4141221C, 40'h7F49494941, 40'h7F09090101, 40'h3E41415132,
    40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
    40'h7F0204027F, 40'h7F0408107F, 40'h3E4141413E, 40'h7F09090906, 40'h3E4151215E,
    40'h7F09192946, 40'h4649494931, 40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F,
    40'h7F2018207F, 40'h6314081463, 40'h0304780403, 40'h6151494543, 40'h00007F4141,
    40'h0204081020, 40'h41417F0000, 40'h0402010204, 40'h4040404040, 40'h0001020400,
    40'h2054545478, 40'h7F48444438, 40'h3844444420, 40'h384444487F, 40'h3854545418,
    40'h087E090102, 40'h081454543C, 40'h7F08040478, 40'h00447D4000, 40'h2040443D00,
    40'h007F102844, 40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
    40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420, 40'h043F444020,
    40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C, 40'h4428102844, 40'h0C5050503C,
    40'h4464544C44, 40'h0008364100, 40'h00007F0000, 40'h0041360800, 40'h08082A1C08
  };

  // Shadow copy of the block's registers and string state, kept in step with
  // every accepted character and every register write.
  logic [3:0]  scale_reg = 4'd1;
  logic [15:0] fg_reg = 16'hFFFF;
  logic [15:0] bg_reg = 16'h0000;
  logic [15:0] cur_x = '0;
  logic [15:0] cur_y = '0;
  logic        stopped = 1'b0;

  char_word_t  char_queue [$];  // characters waiting to be offered
  row_word_t   row_queue [$];   // row words the block still owes
  char_word_t  char_on_bus;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int error_count = 0;
  int chars_taken = 0;
  int chars_drawn = 0;
  int chars_dropped = 0;
  int rows_checked = 0;
  int settings_used = 0;

  // Works out the row words one accepted character produces, top row first,
  // and advances the shadow cursor. A character at or past the panel edge
  // stops its string; later characters of that string draw nothing until a
  // new string starts.
  function automatic void render_char(input char_word_t w);
    int unsigned s, cw, row, col, sx, sy;
    logic [31:0] sum;
    logic [39:0] g;
    logic [47:0] mask;
    row_word_t   r;
    // A scale of zero draws at scale one; anything above the maximum saturates.
    s = (scale_reg == 0) ? 1 : ((scale_reg > MaxScaleDefault) ? MaxScaleDefault : scale_reg);
    cw = CellCols * s;
    if (w.new_string) begin
      cur_x = w.start_x;
      cur_y = w.start_y;
      stopped = 1'b0;
    end
    if (stopped) begin
      chars_dropped++;
      return;
    end
    if (cur_x >= PanelWidthDefault || cw > PanelWidthDefault) begin
      stopped = 1'b1;
      chars_dropped++;
      return;
    end
    // Anything outside the printable range draws as a blank cell.
    if (w.char_code >= FirstCode && w.char_code < EndCode) begin
      g = glyph_rom[w.char_code - FirstCode];
    end else begin
      g = glyph_rom[0];
    end
    for (row = 0; row < GlyphRows; row++) begin
      mask = '0;
      for (col = 0; col < GlyphCols; col++) begin
        if (g[32 - 8 * col + row]) begin
          for (sx = 0; sx < s; sx++) mask[col * s + sx] = 1'b1;
        end
      end
      // The sixth column of the cell is never set, so it stays background.
      for (sy = 0; sy < s; sy++) begin
        r.x_first = cur_x[8:0];
        sum = cur_x + cw - 1;
        r.x_last = sum[8:0];
        sum = cur_y + row * s + sy;
        r.row_y = sum[15:0];
        r.pixel_mask = mask;
        r.fg = fg_reg;
        r.bg = bg_reg;
        r.last_row = (row == GlyphRows - 1) && (sy == s - 1);
        row_queue.push_back(r);
      end
    end
    cur_x = cur_x + cw[15:0];
    chars_drawn++;
  endfunction

  function automatic void check_field(input string name, input logic [47:0] want,
                                      input logic [47:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      error_count++;
    end
  endfunction

  // Input side: offers queued characters, idling at random, and predicts the
  // output of each character at the edge where the block takes it. A word
  // that is on the bus stays there unchanged until it is taken.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        render_char(char_on_bus);
        chars_taken++;
      end
      if (!s_tvalid || s_tready) begin
        if (char_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          char_on_bus = char_queue.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= {char_on_bus.start_y, char_on_bus.start_x, char_on_bus.char_code};
          s_tuser <= char_on_bus.new_string;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Output side: stalls at random, or for a long stretch on request, and
  // checks every row word taken against the oldest one still owed.
  always @(posedge clk) begin
    row_word_t got, want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.x_first = m_tdata[8:0];
        got.x_last = m_tdata[17:9];
        got.row_y = m_tdata[33:18];
        got.pixel_mask = m_tdata[81:34];
        got.fg = m_tdata[97:82];
        got.bg = m_tdata[113:98];
        got.last_row = m_tlast;
        if (row_queue.size() == 0) begin
          $display("%0t: row word with nothing expected, actual y %0h mask %0h",
                   $time, got.row_y, got.pixel_mask);
          error_count++;
        end else begin
          want = row_queue.pop_front();
          check_field("window_x_first", want.x_first, got.x_first);
          check_field("window_x_last", want.x_last, got.x_last);
          check_field("row_y", want.row_y, got.row_y);
          check_field("pixel_mask", want.pixel_mask, got.pixel_mask);
          check_field("fg_out", want.fg, got.fg);
          check_field("bg_out", want.bg, got.bg);
          check_field("last_row", want.last_row, got.last_row);
          rows_checked++;
        end
      end
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = LongHold;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Ends the run if no word moves on any channel for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WatchdogLimit) begin
      $display("%0t: watchdog expired, %0d row words still owed", $time, row_queue.size());
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic void queue_char(input logic [7:0] code, input logic fresh,
                                     input logic [15:0] x, input logic [15:0] y);
    char_word_t w;
    w.char_code = code;
    w.new_string = fresh;
    w.start_x = x;
    w.start_y = y;
    char_queue.push_back(w);
  endfunction

  function automatic logic [7:0] pick_code();
    if ($urandom_range(99) < 85) return 8'($urandom_range(FirstCode, EndCode - 1));
    return 8'($urandom_range(0, 255));
  endfunction

  // Mostly well-formed strings: a start word followed by a short run of
  // characters, with the start column usually on the panel so that the run
  // draws and may reach the right edge. The rest is single noise words.
  function automatic void queue_random_strings(input int count);
    int n, len, i;
    logic [15:0] x;
    n = 0;
    while (n < count) begin
      if ($urandom_range(99) < 75) begin
        x = ($urandom_range(99) < 85) ? 16'($urandom_range(0, PanelWidthDefault - 1))
                                      : 16'($urandom);
        len = $urandom_range(1, 6);
        queue_char(pick_code(), 1'b1, x, 16'($urandom));
        for (i = 1; i < len; i++) queue_char(pick_code(), 1'b0, 16'($urandom), 16'($urandom));
        n += len;
      end else begin
        queue_char(8'($urandom), 1'($urandom_range(1)), 16'($urandom), 16'($urandom));
        n++;
      end
    end
  endfunction

  // Waits until every queued character is taken and every row word is out,
  // then lets characters that draw nothing clear the block.
  task automatic drain();
    do @(posedge clk); while (char_queue.size() != 0 || s_tvalid || row_queue.size() != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Called right after a rising edge; leaves cfg_valid high on return so that
  // writes follow back to back.
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      RegGlyphScale: scale_reg = value[3:0];
      RegFgColour:   fg_reg = value;
      RegBgColour:   bg_reg = value;
      default: ;
    endcase
  endtask

  task automatic program_regs(input logic [15:0] scale_word, input logic [15:0] fg,
                              input logic [15:0] bg);
    write_reg(RegGlyphScale, scale_word);
    write_reg(RegFgColour, fg);
    write_reg(RegBgColour, bg);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  initial begin
    logic [15:0] scale_words [PhaseCount];
    logic [15:0] fg, bg;
    int p;
    // Scale zero, the maximum, a value past the maximum, a write with junk in
    // the unused upper bits, then ordinary scales.
    scale_words = '{16'd0, 16'd8, 16'd15, 16'hABC3, 16'd2, 16'd1, 16'($urandom_range(1, 8))};

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 30;
    recv_idle_pct = 73;

    // Directed characters at the reset settings. The first two come before
    // any string has started and so draw from the reset cursor at the origin.
    queue_char(8'd72, 1'b0, 16'hFFFF, 16'hFFFF);
    queue_char(8'd0, 1'b0, 16'h0000, 16'h0000);
    // Codes at both ends of the printable range and non-printable codes on both sides of it, which draw blank.
    queue_char(8'd31, 1'b1, 16'd0, 16'd0);
    queue_char(FirstCode, 1'b0, 16'd0, 16'd0);
    queue_char(8'd126, 1'b0, 16'd0, 16'd0);
    queue_char(EndCode, 1'b0, 16'd0, 16'd0);
    queue_char(8'd128, 1'b0, 16'd0, 16'd0);
    queue_char(8'd255, 1'b0, 16'd0, 16'd0);
    // A string near the right edge: two characters fit, the third stops the
    // string and the fourth is dropped along with it.
    queue_char(8'd87, 1'b1, 16'd228, 16'd100);
    queue_char(8'd35, 1'b0, 16'd0, 16'd0);
    queue_char(8'd64, 1'b0, 16'd0, 16'd0);
    queue_char(8'd65, 1'b0, 16'd0, 16'd0);
    // Strings that start off the panel draw nothing.
    queue_char(8'd90, 1'b1, 16'hFFFF, 16'd0);
    queue_char(8'd48, 1'b1, 16'd240, 16'd50);
    // Last column that still draws, with the rows wrapping past the bottom.
    queue_char(8'd97, 1'b1, 16'd239, 16'd65533);
    queue_char(8'd103, 1'b0, 16'd0, 16'd0);
    queue_char(8'd126, 1'b1, 16'd5, 16'hFFFF);
    queue_char(8'd0, 1'b0, 16'hAAAA, 16'h5555);
    drain();

    for (p = 0; p < PhaseCount; p++) begin
      // Each phase runs at its own register settings, written while idle.
      if (p == 3) begin
        send_idle_pct = 73;
        recv_idle_pct = 30;
      end
      if (p == 5) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (p)
        0: begin fg = 16'h0000; bg = 16'hFFFF; end
        1: begin fg = 16'hF800; bg = 16'h07E0; end
        5: begin fg = 16'hFFFF; bg = 16'h0000; end
        default: begin fg = 16'($urandom); bg = 16'($urandom); end
      endcase
      program_regs(scale_words[p], fg, bg);
      queue_random_strings(PhaseChars);
      // With nothing idling, hold the output off long enough for the job
      // queue to fill and the input to stall behind it.
      if (p == 5) hold_req++;
      drain();
    end

    $display("Run covered %0d characters (%0d drawn, %0d dropped) under %0d register settings,",
             chars_taken, chars_drawn, chars_dropped, settings_used + 1);
    $display("with %0d row words checked across scales 0 to 15 and a long output stall.",
             rows_checked);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/sgr_pkg.sv
hw/rtl/sgr_front.sv
hw/rtl/sgr_queue.sv
hw/rtl/sgr_back.sv
hw/rtl/scaled_glyph_row_generator_core.sv
sim/tb_top.sv
